/* rtl/core/bdim_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdim_pkg
// Shared types and constants for the b-tagged dijet invariant mass block.
// ----------------------------------------------------------------------------
package bdim_pkg;

  // register indexes of the write port
  localparam logic REG_BIN_COUNT = 1'b0;
  localparam logic REG_BIN_WIDTH = 1'b1;

  localparam logic [10:0] BIN_COUNT_RST = 11'd1000;
  localparam logic [19:0] BIN_WIDTH_RST = 20'd1000;
  localparam logic [10:0] MAX_BINS      = 11'd1024;

  // Q30 constants
  localparam logic [30:0] Q_ONE      = 31'h4000_0000;
  localparam logic [29:0] LN2_Q30    = 30'd744261118;
  localparam logic [31:0] PI_Q30     = 32'd3373259426;
  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;

  // floor(2^35 / LN2_Q30), estimate for the range reduction of eta
  localparam logic [5:0] LN2_RCP = 6'((64'd1 << 35) / 64'(LN2_Q30));

  localparam logic [5:0] SHIFT_MAX = 6'd40;
  localparam logic [4:0] EXP_TERMS = 5'd16;
  localparam logic [4:0] COS_TERMS = 5'd20;

  localparam int JOB_DEPTH = 4;
  localparam int JOB_AW    = 2;
  localparam int JOB_CW    = 3;

  typedef struct packed {
    logic [23:0]        pt_mev;
    logic signed [15:0] eta_q12;
    logic signed [15:0] phi_q13;
    logic               is_btagged;
    logic               last_jet;
  } jet_t;

  typedef struct packed {
    logic [31:0] mass_mev;
    logic [9:0]  bin_index;
    logic        overflow;
  } res_t;

  typedef struct packed {
    logic [23:0]        pt;
    logic signed [15:0] eta;
    logic signed [15:0] phi;
  } kin_t;

  typedef struct packed {
    kin_t j1;
    kin_t j2;
  } job_t;

  typedef struct packed {
    logic [10:0] bin_count;
    logic [19:0] bin_width;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
    logic [31:0] remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

/* rtl/core/bdim_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdim_front
// Event tracker: keeps the first two b-jets of an event and issues a job.
// ----------------------------------------------------------------------------
module bdim_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire bdim_pkg::jet_t jet,
  output logic                job_push,
  output bdim_pkg::job_t      job
);

  logic [1:0]     seen;
  logic [1:0]     seen_next;
  bdim_pkg::kin_t first;
  bdim_pkg::kin_t second;
  bdim_pkg::kin_t first_next;
  bdim_pkg::kin_t second_next;
  bdim_pkg::kin_t cur;

  always_comb begin
    cur.pt      = jet.pt_mev;
    cur.eta     = jet.eta_q12;
    cur.phi     = jet.phi_q13;
    first_next  = first;
    second_next = second;
    seen_next   = seen;
    // b-jets beyond the second are dropped
    if (jet.is_btagged && seen != 2'd2) begin
      if (seen == 2'd0) begin
        first_next = cur;
      end else begin
        second_next = cur;
      end
      seen_next = seen + 2'd1;
    end
  end

  assign job_push = accept && jet.last_jet && seen_next == 2'd2;
  assign job.j1   = first_next;
  assign job.j2   = second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 2'd0;
    end else if (accept) begin
      seen <= jet.last_jet ? 2'd0 : seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first  <= first_next;
      second <= second_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/bdim_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdim_fifo
// Short job queue between the event tracker and the mass engine.
// ----------------------------------------------------------------------------
module bdim_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire bdim_pkg::job_t wdata,
  input  wire logic           rd,
  output logic                full,
  output logic                empty,
  output bdim_pkg::job_t      head
);

  bdim_pkg::job_t                  mem [bdim_pkg::JOB_DEPTH];
  logic [bdim_pkg::JOB_AW-1:0]     wptr;
  logic [bdim_pkg::JOB_AW-1:0]     rptr;
  logic [bdim_pkg::JOB_CW-1:0]     count;

  assign full  = count == bdim_pkg::JOB_CW'(bdim_pkg::JOB_DEPTH);
  assign empty = count == '0;
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/bdim_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdim_div
// Shared restoring divider, 64-bit dividend by 32-bit divisor, 1 bit a cycle.
// ----------------------------------------------------------------------------
module bdim_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bdim_pkg::div_req_t req,
  output bdim_pkg::div_rsp_t      rsp
);

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [63:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem, quo[63]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd63;
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= ge ? 32'(rem_sh - {1'b0, dvs}) : rem_sh[31:0];
        quo <= {quo[62:0], ge};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule
`default_nettype wire

/* rtl/core/bdim_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdim_back
// Mass engine: cosh and cos series, pt product, square root and binning.
// ----------------------------------------------------------------------------
module bdim_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bdim_pkg::cfg_t     cfg,
  input  wire logic               job_avail,
  input  wire bdim_pkg::job_t     job,
  output logic                    job_pop,
  output bdim_pkg::div_req_t      dreq,
  input  wire bdim_pkg::div_rsp_t drsp,
  output logic                    res_valid,
  output bdim_pkg::res_t          res_out,
  input  wire logic               res_take
);

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_PREP  = 19'h00002,
    S_NDIV  = 19'h00004,
    S_EMUL  = 19'h00008,
    S_EDIV  = 19'h00010,
    S_EFIX  = 19'h00020,
    S_RDIV  = 19'h00040,
    S_RWAIT = 19'h00080,
    S_X2    = 19'h00100,
    S_CMUL  = 19'h00200,
    S_CDIV  = 19'h00400,
    S_CFIX  = 19'h00800,
    S_F     = 19'h01000,
    S_MSQ   = 19'h02000,
    S_SQI   = 19'h04000,
    S_SQRT  = 19'h08000,
    S_BIN   = 19'h10000,
    S_BWAIT = 19'h20000,
    S_OUT   = 19'h40000
  } state_t;

  function automatic logic [33:0] phi_fold(input logic [33:0] a);
    logic signed [34:0] dif;
    dif = $signed({1'b0, a}) - $signed({2'b00, bdim_pkg::TWO_PI_Q30});
    if (a > 34'(bdim_pkg::PI_Q30)) begin
      phi_fold = dif[34] ? 34'(-dif) : 34'(dif);
    end else begin
      phi_fold = a;
    end
  endfunction

  function automatic logic [11:0] cos_div(input logic [4:0] k);
    logic [5:0] kk;
    kk      = {k, 1'b0};
    cos_div = 12'(kk - 6'd1) * 12'(kk);
  endfunction

  state_t             state;
  bdim_pkg::job_t     j;
  logic [5:0]         n;
  logic [29:0]        r;
  logic [30:0]        term_e;
  logic [31:0]        esum;
  logic [4:0]         k;
  logic [37:0]        prod;
  logic [63:0]        cosh_v;
  logic [33:0]        a;
  logic [33:0]        x2;
  logic [33:0]        term_c;
  logic signed [63:0] csum;
  logic [63:0]        freg;
  logic [47:0]        pp;
  logic [111:0]       acc;
  logic [1:0]         mcnt;
  logic [63:0]        v;
  logic [63:0]        root;
  logic [63:0]        bitm;
  logic [76:0]        qacc;
  bdim_pkg::res_t     res_r;

  logic signed [16:0] deta;
  logic signed [16:0] dphi;
  logic [16:0]        deta_abs;
  logic [16:0]        dphi_abs;
  logic [34:0]        dval;
  logic [40:0]        nmul;
  logic [34:0]        nrem;
  logic [60:0]        emul;
  logic [63:0]        sq;
  logic [67:0]        cmul;
  logic [63:0]        fdiff;
  logic [63:0]        pmul;
  logic [5:0]         nc;
  logic [63:0]        sq_t;
  logic [19:0]        width;
  logic [10:0]        lim;
  logic               ovf;
  logic [38:0]        rcp_e [32];
  logic [38:0]        rcp_c [32];
  logic               use_cos;
  logic [11:0]        kdiv;
  logic [38:0]        krcp;
  logic [15:0]        kchunk;
  logic [54:0]        kmul;
  logic [38:0]        kq0;
  logic [50:0]        kqd;
  logic [50:0]        krem;
  logic [38:0]        kq;

  // floor(2^38 / divisor) for the series terms, indexed by term number
  for (genvar g = 0; g < 32; g++) begin : g_rcp
    assign rcp_e[g] = 39'((40'd1 << 38) / 40'((g == 0) ? 1 : g));
    assign rcp_c[g] = 39'((40'd1 << 38) / 40'((g == 0) ? 1 : (2 * g - 1) * (2 * g)));
  end

  assign deta     = $signed({j.j1.eta[15], j.j1.eta}) - $signed({j.j2.eta[15], j.j2.eta});
  assign dphi     = $signed({j.j1.phi[15], j.j1.phi}) - $signed({j.j2.phi[15], j.j2.phi});
  assign deta_abs = deta[16] ? 17'(-deta) : 17'(deta);
  assign dphi_abs = dphi[16] ? 17'(-dphi) : 17'(dphi);
  assign dval     = {deta_abs, 18'b0};
  assign nmul     = 41'(dval) * 41'(bdim_pkg::LN2_RCP);
  assign nrem     = dval - 35'(n) * 35'(bdim_pkg::LN2_Q30);
  assign emul     = 61'(term_e) * 61'(r);
  assign sq       = 64'(a[31:0]) * 64'(a[31:0]);
  assign cmul     = 68'(term_c) * 68'(x2);
  assign fdiff    = cosh_v - $unsigned(csum);
  assign pmul     = 64'(pp) * 64'(freg[63:48]);
  assign nc       = (n > bdim_pkg::SHIFT_MAX) ? bdim_pkg::SHIFT_MAX : n;
  assign sq_t     = root + bitm;
  assign width    = (cfg.bin_width == '0) ? 20'd1 : cfg.bin_width;
  assign lim      = (cfg.bin_count > bdim_pkg::MAX_BINS) ? bdim_pkg::MAX_BINS : cfg.bin_count;
  assign ovf      = drsp.quotient >= 64'(lim);

  // term division: reciprocal product summed chunk by chunk, top chunk first, then one correction
  assign use_cos = (state == S_CDIV) || (state == S_CFIX);
  assign kdiv    = use_cos ? cos_div(k) : 12'(k);
  assign krcp    = use_cos ? rcp_c[k] : rcp_e[k];
  assign kmul    = 55'(kchunk) * 55'(krcp);
  assign kq0     = qacc[76:38];
  assign kqd     = 51'(kq0) * 51'(kdiv);
  assign krem    = 51'(prod) - kqd;
  assign kq      = (krem >= 51'(kdiv)) ? kq0 + 39'd1 : kq0;

  always_comb begin
    case (mcnt)
      2'd0:    kchunk = {10'b0, prod[37:32]};
      2'd1:    kchunk = prod[31:16];
      default: kchunk = prod[15:0];
    endcase
  end

  assign job_pop   = state == S_IDLE && job_avail;
  assign res_valid = state == S_OUT;
  assign res_out   = res_r;

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = '0;
    unique case (state)
      S_RDIV: begin
        dreq.start    = 1'b1;
        dreq.dividend = 64'd1 << 60;
        dreq.divisor  = esum;
      end
      S_BIN: begin
        dreq.start    = 1'b1;
        dreq.dividend = 64'(root[31:0]);
        dreq.divisor  = 32'(width);
      end
      default: begin
        dreq.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_avail) begin
            j     <= job;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          a     <= {dphi_abs, 17'b0};
          n     <= nmul[40:35];
          state <= S_NDIV;
        end
        S_NDIV: begin
          // the estimate of n is low by at most one
          if (nrem >= 35'(bdim_pkg::LN2_Q30)) begin
            n <= n + 6'd1;
            r <= 30'(nrem - 35'(bdim_pkg::LN2_Q30));
          end else begin
            r <= nrem[29:0];
          end
          term_e <= bdim_pkg::Q_ONE;
          esum   <= 32'(bdim_pkg::Q_ONE);
          k      <= 5'd1;
          state  <= S_EMUL;
        end
        S_EMUL: begin
          // fold the phi gap while the exp series runs
          a     <= phi_fold(a);
          prod  <= 38'(emul[60:30]);
          qacc  <= '0;
          mcnt  <= 2'd0;
          state <= S_EDIV;
        end
        S_EDIV: begin
          qacc <= 77'({qacc, 16'b0}) + 77'(kmul);
          mcnt <= mcnt + 2'd1;
          if (mcnt == 2'd2) begin
            state <= S_EFIX;
          end
        end
        S_EFIX: begin
          term_e <= kq[30:0];
          esum   <= esum + 32'(kq[30:0]);
          if (k == bdim_pkg::EXP_TERMS) begin
            state <= S_RDIV;
          end else begin
            k     <= k + 5'd1;
            state <= S_EMUL;
          end
        end
        S_RDIV: begin
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          if (drsp.done) begin
            cosh_v <= ((64'(esum) << nc) + (drsp.quotient >> nc)) >> 1;
            state  <= S_X2;
          end
        end
        S_X2: begin
          x2     <= sq[63:30];
          term_c <= 34'(bdim_pkg::Q_ONE);
          csum   <= 64'(bdim_pkg::Q_ONE);
          k      <= 5'd1;
          state  <= S_CMUL;
        end
        S_CMUL: begin
          prod  <= cmul[67:30];
          qacc  <= '0;
          mcnt  <= 2'd0;
          state <= S_CDIV;
        end
        S_CDIV: begin
          qacc <= 77'({qacc, 16'b0}) + 77'(kmul);
          mcnt <= mcnt + 2'd1;
          if (mcnt == 2'd2) begin
            state <= S_CFIX;
          end
        end
        S_CFIX: begin
          term_c <= kq[33:0];
          // odd terms subtract
          if (k[0]) begin
            csum <= csum - $signed(64'(kq[33:0]));
          end else begin
            csum <= csum + $signed(64'(kq[33:0]));
          end
          if (k == bdim_pkg::COS_TERMS) begin
            state <= S_F;
          end else begin
            k     <= k + 5'd1;
            state <= S_CMUL;
          end
        end
        S_F: begin
          freg  <= fdiff[63] ? 64'd0 : fdiff;
          pp    <= 48'(j.j1.pt) * 48'(j.j2.pt);
          acc   <= '0;
          mcnt  <= 2'd0;
          state <= S_MSQ;
        end
        S_MSQ: begin
          // 16 bits of the factor per cycle, top chunk first
          acc  <= {acc[95:0], 16'b0} + 112'(pmul);
          freg <= {freg[47:0], 16'b0};
          mcnt <= mcnt + 2'd1;
          if (mcnt == 2'd3) begin
            state <= S_SQI;
          end
        end
        S_SQI: begin
          v     <= (acc[111:93] != '0) ? '1 : acc[92:29];
          root  <= '0;
          bitm  <= 64'd1 << 62;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (v >= sq_t) begin
            v    <= v - sq_t;
            root <= (root >> 1) + bitm;
          end else begin
            root <= root >> 1;
          end
          bitm <= bitm >> 2;
          if (bitm[0]) begin
            state <= S_BIN;
          end
        end
        S_BIN: begin
          state <= S_BWAIT;
        end
        S_BWAIT: begin
          if (drsp.done) begin
            res_r.mass_mev  <= root[31:0];
            res_r.overflow  <= ovf;
            res_r.bin_index <= ovf ? 10'd0 : drsp.quotient[9:0];
            state           <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/btag_dijet_invariant_mass.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// btag_dijet_invariant_mass
// Invariant mass of the first two b-tagged jets of each event, with binning.
// ----------------------------------------------------------------------------
// Jets are taken one per cycle while full is low. Only events with two or
// more b-jets give a result, on their last jet. Such an event is queued (up to
// four events) for the mass engine, which takes one event at a time through
// 36 series terms (the term divisions by small constants use a reciprocal
// product), two divisions through a bit-serial divider (the cosh reciprocal
// and the bin index), a square root and its setup steps. Jet intake stalls
// only when that queue is full.
// Results wait in an output register until popped.
module btag_dijet_invariant_mass (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire bdim_pkg::jet_t jet,
  output logic                empty,
  input  wire logic           pop,
  output bdim_pkg::res_t      result,
  input  wire logic           wr_en,
  input  wire logic           wr_index,
  input  wire logic [19:0]    wr_data
);

  bdim_pkg::cfg_t     cfg;
  logic               accept;
  logic               job_push;
  bdim_pkg::job_t     job_in;
  logic               job_full;
  logic               job_empty;
  logic               job_pop;
  bdim_pkg::job_t     job_head;
  bdim_pkg::div_req_t dreq;
  bdim_pkg::div_rsp_t drsp;
  logic               b_valid;
  bdim_pkg::res_t     b_res;
  logic               load;
  logic               rvalid;

  assign full   = job_full;
  assign accept = push && !job_full;
  assign load   = b_valid && (!rvalid || pop);
  assign empty  = !rvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bin_count <= bdim_pkg::BIN_COUNT_RST;
      cfg.bin_width <= bdim_pkg::BIN_WIDTH_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        bdim_pkg::REG_BIN_COUNT: cfg.bin_count <= wr_data[10:0];
        bdim_pkg::REG_BIN_WIDTH: cfg.bin_width <= wr_data;
        default: cfg.bin_width <= cfg.bin_width;
      endcase
    end
  end

  bdim_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .jet      (jet),
    .job_push (job_push),
    .job      (job_in)
  );

  bdim_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (job_push),
    .wdata (job_in),
    .rd    (job_pop),
    .full  (job_full),
    .empty (job_empty),
    .head  (job_head)
  );

  bdim_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  bdim_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_avail (!job_empty),
    .job       (job_head),
    .job_pop   (job_pop),
    .dreq      (dreq),
    .drsp      (drsp),
    .res_valid (b_valid),
    .res_out   (b_res),
    .res_take  (load)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else if (load) begin
      rvalid <= 1'b1;
    end else if (pop) begin
      rvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= b_res;
    end
  end

`ifndef SYNTHESIS
  a_ovf_bin_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && result.overflow |-> result.bin_index == 10'd0)
    else $error("overflow result with nonzero bin");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !job_full)
    else $error("job queued while queue full");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    b_valid && !load |=> b_valid && $stable(b_res))
    else $error("engine result dropped before hand-off");
`endif

endmodule
`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Streams jets into the b-tagged dijet mass block, predicts each event's mass,
// bin and overflow flag, and compares them item by item as they are popped.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [63:0] LN2 = 64'd744261118;
  localparam logic [63:0] PI  = 64'd3373259426;
  localparam logic [63:0] TPI = 64'd6746518852;
  localparam int WATCHDOG = 40000;

  logic clk;
  logic rst;
  logic push;
  logic full;
  bdim_pkg::jet_t jet;
  logic empty;
  logic pop;
  bdim_pkg::res_t result;
  logic wr_en;
  logic wr_index;
  logic [19:0] wr_data;

  btag_dijet_invariant_mass u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .jet(jet),
    .empty(empty), .pop(pop), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  // predictor state
  logic [10:0] cfg_bins;
  logic [19:0] cfg_width;
  int unsigned bseen;
  bdim_pkg::jet_t bj1, bj2;

  bdim_pkg::jet_t jet_q[$];
  bdim_pkg::res_t mass_q[$];
  int     errors;
  int     idle_cycles;
  bit     hold_rx;
  bit     done_stim;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // floor(a*b / 2^s), saturated
  function automatic logic [63:0] mulsh(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> s;
    if (p[127:64] != 0) return '1;
    return p[63:0];
  endfunction

  function automatic logic [63:0] cosh_fix(int deta);
    logic [63:0] d, n, r, t, s;
    d = 64'(deta < 0 ? -deta : deta) << 18;
    n = d / LN2;
    r = d - n * LN2;
    t = 64'd1 << 30;
    s = t;
    for (int k = 1; k <= 16; k++) begin
      t = mulsh(t, r, 30) / k;
      s += t;
    end
    if (n > 40) n = 40;
    return ((s << n) + (((64'd1 << 60) / s) >> n)) >> 1;
  endfunction

  function automatic longint cos_fix(int dphi);
    longint a, s;
    logic [63:0] t, x2;
    a = longint'(dphi < 0 ? -dphi : dphi) * 131072;
    s = longint'(1) << 30;
    t = 64'd1 << 30;
    for (int i = 0; i < 2; i++) begin
      if (a > longint'(PI)) begin
        a -= longint'(TPI);
        if (a < 0) a = -a;
      end
    end
    x2 = mulsh(a, a, 30);
    for (int k = 1; k <= 20; k++) begin
      t = mulsh(t, x2, 30) / ((2 * k - 1) * (2 * k));
      if (k & 1) s -= longint'(t);
      else s += longint'(t);
    end
    return s;
  endfunction

  function automatic logic [31:0] isqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res[31:0];
  endfunction

  task automatic predict_jet(bdim_pkg::jet_t j);
    longint f;
    logic [63:0] msq, w, lim, bin;
    bdim_pkg::res_t r;
    if (j.is_btagged && bseen < 2) begin
      if (bseen == 0) bj1 = j;
      else bj2 = j;
      bseen++;
    end
    if (!j.last_jet) return;
    if (bseen < 2) begin
      bseen = 0;
      return;
    end
    bseen = 0;
    f = longint'(cosh_fix(int'(bj1.eta_q12) - int'(bj2.eta_q12)))
        - cos_fix(int'(bj1.phi_q13) - int'(bj2.phi_q13));
    if (f < 0) f = 0;
    msq = mulsh(64'(bj1.pt_mev) * 64'(bj2.pt_mev), f, 29);
    r.mass_mev = isqrt(msq);
    w = cfg_width == 0 ? 64'd1 : 64'(cfg_width);
    lim = 64'(cfg_bins);
    if (lim > 1024) lim = 1024;
    bin = 64'(r.mass_mev) / w;
    r.overflow = bin >= lim;
    r.bin_index = r.overflow ? 10'd0 : bin[9:0];
    mass_q.push_back(r);
  endtask

  // sender: bursts and gaps
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (push && !full) begin
        predict_jet(jet_q.pop_front());
      end
      if (!(push && full)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          push <= 1'b0;
        end else if (jet_q.size() > 0 && !wr_en) begin
          push <= 1'b1;
          jet <= jet_q[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(40, 1);
            gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver: own stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (mass_q.size() == 0) begin
          $error("result with nothing expected: mass_mev %0d", result.mass_mev);
          errors++;
        end else begin
          bdim_pkg::res_t e;
          e = mass_q.pop_front();
          if (result.mass_mev !== e.mass_mev) begin
            $error("mass_mev expected %0d actual %0d", e.mass_mev, result.mass_mev);
            errors++;
          end
          if (result.bin_index !== e.bin_index) begin
            $error("bin_index expected %0d actual %0d", e.bin_index, result.bin_index);
            errors++;
          end
          if (result.overflow !== e.overflow) begin
            $error("overflow expected %0d actual %0d", e.overflow, result.overflow);
            errors++;
          end
        end
      end
      pop <= !hold_rx && ($urandom_range(7, 0) < 5);
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || hold_rx) idle_cycles <= 0;
    else if (jet_q.size() > 0 || mass_q.size() > 0 || !done_stim) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic bdim_pkg::jet_t rand_jet(bit btag, bit last);
    bdim_pkg::jet_t j;
    j.pt_mev = ($urandom_range(3, 0) == 0) ? 24'($urandom) : 24'($urandom_range(500000, 0));
    j.eta_q12 = ($urandom_range(3, 0) == 0) ? 16'($urandom)
                : 16'($signed($urandom_range(20000, 0)) - 10000);
    j.phi_q13 = 16'($signed($urandom_range(51472, 0)) - 25736);
    j.is_btagged = btag;
    j.last_jet = last;
    return j;
  endfunction

  task automatic add_event(int njets, int nb);
    int bpos[$];
    for (int i = 0; i < njets; i++) begin
      jet_q.push_back(rand_jet(0, i == njets - 1));
      if (i < nb || $urandom_range(1, 0)) bpos.push_back(i);
    end
    bpos.shuffle();
    for (int i = 0; i < nb && i < bpos.size(); i++)
      jet_q[jet_q.size() - njets + bpos[i]].is_btagged = 1'b1;
  endtask

  task automatic mk(logic [23:0] pt, logic [15:0] eta, logic [15:0] phi, bit b, bit l);
    bdim_pkg::jet_t j;
    j.pt_mev = pt;
    j.eta_q12 = eta;
    j.phi_q13 = phi;
    j.is_btagged = b;
    j.last_jet = l;
    jet_q.push_back(j);
  endtask

  task automatic drain();
    while (jet_q.size() > 0 || push || mass_q.size() > 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [19:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == bdim_pkg::REG_BIN_COUNT) cfg_bins = val[10:0];
    else cfg_width = val;
  endtask

  task automatic random_events(int items);
    int n, stop;
    stop = jet_q.size() + items;
    while (jet_q.size() < stop) begin
      n = $urandom_range(5, 1);
      if ($urandom_range(9, 0) < 7) add_event(n, 2 + $urandom_range(1, 0));
      else add_event(n, $urandom_range(1, 0));
    end
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    wr_en = 1'b0;
    wr_index = bdim_pkg::REG_BIN_COUNT;
    wr_data = '0;
    jet = '0;
    errors = 0;
    hold_rx = 1'b0;
    done_stim = 1'b0;
    cfg_bins = bdim_pkg::BIN_COUNT_RST;
    cfg_width = bdim_pkg::BIN_WIDTH_RST;
    bseen = 0;
    bj1 = '0;
    bj2 = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, identical jets, third b-jet, non-b events
    mk(24'hFFFFFF, 16'sh7FFF, 16'sd25736, 1, 0);
    mk(24'hFFFFFF, 16'sh8000, -16'sd25736, 1, 1);
    mk(24'd0, 16'd0, 16'd0, 1, 0);
    mk(24'd1000, 16'd0, 16'd0, 1, 1);
    mk(24'd50000, 16'd100, 16'd200, 1, 0);
    mk(24'd50000, 16'd100, 16'd200, 1, 1);
    mk(24'd40000, 16'd4096, 16'd0, 1, 0);
    mk(24'd40000, -16'sd4096, 16'd25000, 0, 0);
    mk(24'd30000, 16'd0, -16'sd25000, 1, 0);
    mk(24'd99999, 16'd9, 16'd9, 1, 1);
    mk(24'd12345, 16'd1, 16'd1, 1, 1);
    mk(24'd12345, 16'd1, 16'd1, 0, 0);
    mk(24'd12345, 16'd1, 16'd1, 0, 1);
    mk(24'd200000, 16'd30000, 16'd0, 1, 0);
    mk(24'd200000, -16'sd30000, 16'd0, 1, 1);
    drain();

    write_reg(bdim_pkg::REG_BIN_COUNT, 20'd1);
    write_reg(bdim_pkg::REG_BIN_WIDTH, 20'd1);
    random_events(300);
    drain();

    write_reg(bdim_pkg::REG_BIN_COUNT, 20'd2047);
    write_reg(bdim_pkg::REG_BIN_WIDTH, 20'hFFFFF);
    random_events(300);
    // long hold-off so the job queue fills and intake stalls
    hold_rx = 1'b1;
    repeat (20000) @(posedge clk);
    hold_rx = 1'b0;
    drain();

    write_reg(bdim_pkg::REG_BIN_COUNT, 20'd0);
    write_reg(bdim_pkg::REG_BIN_WIDTH, 20'd0);
    random_events(250);
    drain();

    write_reg(bdim_pkg::REG_BIN_COUNT, 20'd1024);
    write_reg(bdim_pkg::REG_BIN_WIDTH, 20'd300);
    random_events(300);
    drain();

    write_reg(bdim_pkg::REG_BIN_COUNT, 20'($urandom_range(1024, 1)));
    write_reg(bdim_pkg::REG_BIN_WIDTH, 20'($urandom_range(5000, 1)));
    random_events(280);
    drain();
    done_stim = 1'b1;

    if (errors == 0 && mass_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
